// ----- rtl/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and constants of the periodic timer table
// Operation codes, status codes, default sizes.
// ----------------------------------------------------------------------------
package ptt_pkg;
    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_TIME_WIDTH  = 32;

    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_ADDU = 3'd2;
    localparam logic [2:0] OP_REM  = 3'd3;
    localparam logic [2:0] OP_DEC  = 3'd4;
    localparam logic [2:0] OP_QRY  = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;
    localparam logic [1:0] ST_DUP  = 2'd3;
endpackage

// ----- rtl/ptt_if.sv -----
// ----------------------------------------------------------------------------
// ptt_in_if / ptt_out_if: valid/ready channels of the timer table
// Input item channel and result item channel.
// ----------------------------------------------------------------------------
interface ptt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [7:0]  task_id;
    logic [31:0] time_delta;
    logic [31:0] interval;
    logic [15:0] count;
    modport source (output valid, operation, task_id, time_delta, interval, count,
                    input ready);
    modport sink   (input valid, operation, task_id, time_delta, interval, count,
                    output ready);
endinterface

interface ptt_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  status;
    logic [7:0]  fired_id;
    logic [32:0] fire_count;
    logic        found;
    logic [31:0] remaining_time;
    logic        last;
    modport source (output valid, kind, status, fired_id, fire_count, found,
                    remaining_time, last, input ready);
    modport sink   (input valid, kind, status, fired_id, fire_count, found,
                    remaining_time, last, output ready);
endinterface

// ----- rtl/ptt_div.sv -----
// ----------------------------------------------------------------------------
// ptt_div: shared restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptt_div #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  q_reg;
    logic [W:0]    r_reg;
    logic [W-1:0]  d_reg;
    logic [W:0]    trial;

    assign trial = {r_reg[W-1:0], q_reg[W-1]} - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
                q_reg    <= dividend;
                r_reg    <= '0;
                d_reg    <= divisor;
            end
            else if (busy_reg)
            begin
                if (trial[W])
                    r_reg <= {r_reg[W-1:0], q_reg[W-1]};
                else
                    r_reg <= trial;
                q_reg   <= {q_reg[W-2:0], ~trial[W]};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign quotient  = q_reg;
    assign remainder = r_reg[W-1:0];
endmodule

// ----- rtl/ptt_cell.sv -----
// ----------------------------------------------------------------------------
// ptt_cell: one slot of the timer chain
// Holds one entry; loads from its upper neighbor when the chain closes up,
// or from the controller when written directly.
// ----------------------------------------------------------------------------
module ptt_cell #(
    parameter int TW = 32
) (
    input  logic          clk,
    input  logic          shift,
    input  logic          wr,
    input  logic [7:0]    nb_id,
    input  logic [TW-1:0] nb_per,
    input  logic [TW-1:0] nb_left,
    input  logic [15:0]   nb_rep,
    input  logic          nb_fe,
    input  logic [7:0]    w_id,
    input  logic [TW-1:0] w_per,
    input  logic [TW-1:0] w_left,
    input  logic [15:0]   w_rep,
    input  logic          w_fe,
    output logic [7:0]    id,
    output logic [TW-1:0] per,
    output logic [TW-1:0] left,
    output logic [15:0]   rep,
    output logic          fe
);
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            id <= w_id; per <= w_per; left <= w_left; rep <= w_rep; fe <= w_fe;
        end
        else if (shift)
        begin
            id <= nb_id; per <= nb_per; left <= nb_left; rep <= nb_rep; fe <= nb_fe;
        end
    end
endmodule

// ----- rtl/periodic_timer_table.sv -----
// ----------------------------------------------------------------------------
// periodic_timer_table: ordered table of periodic timers
// Chain of entry cells walked by a sequencer with a shared divider.
// ----------------------------------------------------------------------------
// One item at a time. Add-unique, remove, decrease and query walk the chain
// one slot per cycle, with an extra shift step per removed entry while the
// cells above it shift down; a plain add goes straight to its reply. A tick
// visits each entry; a firing entry with overshoot of a period or more runs
// the shared bit-serial divider, and a tick also waits while the result side
// stalls. Results leave through an output register; each fire report waits
// there until taken.
module periodic_timer_table #(
    parameter int TABLE_DEPTH = ptt_pkg::DEF_TABLE_DEPTH,
    parameter int TIME_WIDTH  = ptt_pkg::DEF_TIME_WIDTH
) (
    input  logic   clk,
    input  logic   rst_n,
    ptt_in_if.sink   in_ch,
    ptt_out_if.source out_ch
);
    import ptt_pkg::*;

    localparam int TW = TIME_WIDTH;
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_REPLY = 3'd5;

    logic [2:0]    state_reg;
    logic [2:0]    op_reg;
    logic [7:0]    tid_reg;
    logic [TW-1:0] delta_reg;
    logic [TW-1:0] per_in_reg;
    logic [15:0]   cnt_reg;
    logic [NW-1:0] n_reg;
    logic [NW-1:0] i_reg;
    logic          any_reg;
    logic          stop_reg;
    logic          hit_reg;
    logic          ovalid_reg;

    logic [7:0]    c_id   [TABLE_DEPTH];
    logic [TW-1:0] c_per  [TABLE_DEPTH];
    logic [TW-1:0] c_left [TABLE_DEPTH];
    logic [15:0]   c_rep  [TABLE_DEPTH];
    logic          c_fe   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] c_shift, c_wr;

    logic [7:0]    w_id;
    logic [TW-1:0] w_per, w_left;
    logic [15:0]   w_rep;
    logic          w_fe;

    // pending fire report
    logic [7:0]    f_id_reg;
    logic [32:0]   f_cnt_reg;

    logic          div_start, div_done;
    logic [TW-1:0] div_q, div_r;

    // current slot
    logic [IW-1:0] ix;
    logic [7:0]    s_id;
    logic [TW-1:0] s_per, s_left;
    logic [15:0]   s_rep;
    logic          s_fe;
    assign ix     = i_reg[IW-1:0];
    assign s_id   = c_id[ix];
    assign s_per  = c_per[ix];
    assign s_left = c_left[ix];
    assign s_rep  = c_rep[ix];
    assign s_fe   = c_fe[ix];

    logic          in_range;
    assign in_range = (i_reg < n_reg);

    logic [TW-1:0] e_now;
    assign e_now = delta_reg - s_left;

    ptt_div #(.W(TW)) u_div (
        .clk, .rst_n, .start(div_start), .dividend(e_now), .divisor(w_per),
        .done(div_done), .quotient(div_q), .remainder(div_r)
    );

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            if (g < TABLE_DEPTH - 1)
            begin : g_mid
                ptt_cell #(.TW(TW)) u_cell (
                    .clk, .shift(c_shift[g]), .wr(c_wr[g]),
                    .nb_id(c_id[g+1]), .nb_per(c_per[g+1]), .nb_left(c_left[g+1]),
                    .nb_rep(c_rep[g+1]), .nb_fe(c_fe[g+1]),
                    .w_id, .w_per, .w_left, .w_rep, .w_fe,
                    .id(c_id[g]), .per(c_per[g]), .left(c_left[g]),
                    .rep(c_rep[g]), .fe(c_fe[g])
                );
            end
            else
            begin : g_end
                ptt_cell #(.TW(TW)) u_cell (
                    .clk, .shift(1'b0), .wr(c_wr[g]),
                    .nb_id(c_id[g]), .nb_per(c_per[g]), .nb_left(c_left[g]),
                    .nb_rep(c_rep[g]), .nb_fe(c_fe[g]),
                    .w_id, .w_per, .w_left, .w_rep, .w_fe,
                    .id(c_id[g]), .per(c_per[g]), .left(c_left[g]),
                    .rep(c_rep[g]), .fe(c_fe[g])
                );
            end
        end
    endgenerate

    // fire count after the catch-up division, then clamp against repeats
    logic [32:0]   fires_raw;
    logic [32:0]   fires_fin;
    logic [15:0]   rep_after;
    logic          drop_after;
    always_comb
    begin
        fires_fin  = fires_raw;
        rep_after  = s_rep;
        drop_after = 1'b0;
        if (!s_fe)
        begin
            if (fires_raw >= {17'd0, s_rep})
            begin
                fires_fin  = {17'd0, s_rep};
                rep_after  = '0;
                drop_after = 1'b1;
            end
            else
                rep_after = s_rep - fires_raw[15:0];
        end
    end

    logic [TW-1:0] new_left;
    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            fires_raw = 33'(div_q) + 33'd1;
            new_left  = div_r;
        end
        else
        begin
            fires_raw = 33'd1;
            new_left  = s_per - e_now;
        end
    end

    // outputs
    logic          o_kind_reg, o_found_reg, o_last_reg;
    logic [1:0]    o_st_reg;
    logic [7:0]    o_id_reg;
    logic [32:0]   o_cnt_reg;
    logic [31:0]   o_rem_reg;

    assign out_ch.valid          = ovalid_reg;
    assign out_ch.kind           = o_kind_reg;
    assign out_ch.status         = o_st_reg;
    assign out_ch.fired_id       = o_id_reg;
    assign out_ch.fire_count     = o_cnt_reg;
    assign out_ch.found          = o_found_reg;
    assign out_ch.remaining_time = o_rem_reg;
    assign out_ch.last           = o_last_reg;

    assign in_ch.ready = (state_reg == S_IDLE) && !ovalid_reg;

    logic out_free;
    assign out_free = !ovalid_reg || out_ch.ready;

    // cycles in which the output register takes a new item
    logic need_div, fire_now, fire_div, flush_now, reply_now, o_load;
    assign need_div  = (s_per != '0) && (e_now >= s_per);
    assign fire_now  = (state_reg == S_WALK) && in_range && !stop_reg
                       && (op_reg == OP_TICK) && (s_left <= delta_reg)
                       && !need_div && out_free;
    assign fire_div  = (state_reg == S_DIV) && div_done && out_free;
    assign flush_now = (state_reg == S_WALK) && (!in_range || stop_reg)
                       && (op_reg == OP_TICK) && any_reg && out_free;
    assign reply_now = (state_reg == S_REPLY) && !ovalid_reg;
    assign o_load    = ((fire_now || fire_div) && any_reg) || flush_now || reply_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (o_load)
            ovalid_reg <= 1'b1;
        else if (out_ch.ready)
            ovalid_reg <= 1'b0;
    end

    logic [NW-1:0] i_plus;
    assign i_plus = i_reg + 1'b1;

    always_comb
    begin
        c_shift   = '0;
        c_wr      = '0;
        w_id      = tid_reg;
        w_per     = per_in_reg;
        w_left    = per_in_reg;
        w_rep     = (cnt_reg == 16'd0) ? 16'd1 : cnt_reg;
        w_fe      = (cnt_reg == 16'd0);
        div_start = 1'b0;
        if (state_reg == S_SHIFT)
        begin
            for (int k = 0; k < TABLE_DEPTH; k++)
                c_shift[k] = (NW'(k) >= i_reg);
        end
        if (state_reg != S_IDLE && state_reg != S_REPLY && state_reg != S_SHIFT)
        begin
            w_id  = s_id;
            w_per = s_per;
            w_fe  = s_fe;
            w_rep = s_rep;
            w_left = s_left;
        end
        if (state_reg == S_WALK && in_range)
        begin
            if (op_reg == OP_TICK)
            begin
                if (s_left <= delta_reg && need_div)
                    div_start = 1'b1;
                else if (s_left <= delta_reg)
                begin
                    if (out_free)
                    begin
                        w_left = new_left; w_rep = rep_after;
                        c_wr[ix] = 1'b1;
                    end
                end
                else
                begin
                    w_left = s_left - delta_reg;
                    c_wr[ix] = 1'b1;
                end
            end
            else if (op_reg == OP_DEC && !stop_reg && s_id == tid_reg
                     && s_rep > cnt_reg)
            begin
                w_rep = s_rep - cnt_reg; w_left = s_per;
                c_wr[ix] = 1'b1;
            end
        end
        if (state_reg == S_DIV && div_done && out_free)
        begin
            w_left = new_left; w_rep = rep_after;
            c_wr[ix] = 1'b1;
        end
        if (state_reg == S_REPLY && (op_reg == OP_ADD || op_reg == OP_ADDU)
            && !hit_reg && per_in_reg != '0 && n_reg < NW'(TABLE_DEPTH))
            c_wr[n_reg[IW-1:0]] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            n_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        op_reg     <= in_ch.operation;
                        tid_reg    <= in_ch.task_id;
                        delta_reg  <= TW'(in_ch.time_delta);
                        per_in_reg <= TW'(in_ch.interval);
                        cnt_reg    <= in_ch.count;
                        i_reg      <= '0;
                        any_reg    <= 1'b0;
                        stop_reg   <= 1'b0;
                        hit_reg    <= 1'b0;
                        o_rem_reg  <= '0;
                        state_reg  <= (in_ch.operation == OP_TICK ||
                                       in_ch.operation == OP_ADDU ||
                                       in_ch.operation == OP_REM ||
                                       in_ch.operation == OP_DEC ||
                                       in_ch.operation == OP_QRY) ? S_WALK : S_REPLY;
                    end
                end
                S_WALK:
                begin
                    if (!in_range || stop_reg)
                    begin
                        if (op_reg == OP_TICK && any_reg)
                        begin
                            if (out_free)
                            begin
                                // flush the held report as last
                                o_kind_reg  <= 1'b1;
                                o_st_reg    <= ST_OK;
                                o_id_reg    <= f_id_reg;
                                o_cnt_reg   <= f_cnt_reg;
                                o_found_reg <= 1'b0;
                                o_rem_reg   <= '0;
                                o_last_reg  <= 1'b1;
                                state_reg   <= S_IDLE;
                            end
                        end
                        else
                            state_reg <= S_REPLY;
                    end
                    else
                    begin
                        case (op_reg)
                            OP_TICK:
                            begin
                                if (s_left <= delta_reg)
                                begin
                                    if (need_div)
                                        state_reg <= S_DIV;
                                    else if (out_free)
                                    begin
                                        // release the previous held report
                                        if (any_reg)
                                        begin
                                            o_kind_reg  <= 1'b1;
                                            o_st_reg    <= ST_OK;
                                            o_id_reg    <= f_id_reg;
                                            o_cnt_reg   <= f_cnt_reg;
                                            o_found_reg <= 1'b0;
                                            o_rem_reg   <= '0;
                                            o_last_reg  <= 1'b0;
                                        end
                                        f_id_reg  <= s_id;
                                        f_cnt_reg <= fires_fin;
                                        state_reg <= S_EMIT;
                                        stop_reg  <= drop_after;
                                    end
                                end
                                else
                                    i_reg <= i_plus;
                            end
                            OP_ADDU:
                            begin
                                if (s_id == tid_reg)
                                begin
                                    hit_reg  <= 1'b1;
                                    stop_reg <= 1'b1;
                                end
                                else
                                    i_reg <= i_plus;
                            end
                            OP_REM:
                            begin
                                if (s_id == tid_reg)
                                    state_reg <= S_SHIFT;
                                else
                                    i_reg <= i_plus;
                            end
                            OP_DEC:
                            begin
                                if (s_id != tid_reg)
                                    i_reg <= i_plus;
                                else if (s_rep > cnt_reg)
                                    stop_reg <= 1'b1;
                                else
                                begin
                                    if (s_rep == cnt_reg)
                                        stop_reg <= 1'b1;
                                    cnt_reg   <= cnt_reg - s_rep;
                                    state_reg <= S_SHIFT;
                                end
                            end
                            default:
                            begin
                                if (s_id == tid_reg)
                                begin
                                    hit_reg   <= 1'b1;
                                    o_rem_reg <= 32'(s_left);
                                    stop_reg  <= 1'b1;
                                end
                                else
                                    i_reg <= i_plus;
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (out_free)
                        begin
                            if (any_reg)
                            begin
                                o_kind_reg  <= 1'b1;
                                o_st_reg    <= ST_OK;
                                o_id_reg    <= f_id_reg;
                                o_cnt_reg   <= f_cnt_reg;
                                o_found_reg <= 1'b0;
                                o_rem_reg   <= '0;
                                o_last_reg  <= 1'b0;
                            end
                            f_id_reg  <= s_id;
                            f_cnt_reg <= fires_fin;
                            stop_reg  <= drop_after;
                            state_reg <= S_EMIT;
                        end
                        else
                            state_reg <= S_WALK; // redo, divider re-runs
                    end
                end
                S_EMIT:
                begin
                    // this report is now held until the next one or the end
                    any_reg <= 1'b1;
                    stop_reg <= 1'b0;
                    if (stop_reg)
                        state_reg <= S_SHIFT;
                    else
                    begin
                        i_reg     <= i_plus;
                        state_reg <= S_WALK;
                    end
                end
                S_SHIFT:
                begin
                    n_reg <= n_reg - 1'b1;
                    if (op_reg != OP_DEC)
                        stop_reg <= 1'b0;
                    state_reg <= S_WALK;
                end
                default:
                begin
                    if (!ovalid_reg)
                    begin
                        o_kind_reg  <= 1'b0;
                        o_id_reg    <= '0;
                        o_cnt_reg   <= '0;
                        o_last_reg  <= 1'b1;
                        o_found_reg <= (op_reg == OP_QRY) && hit_reg;
                        if (!(op_reg == OP_QRY && hit_reg))
                            o_rem_reg <= '0;
                        o_st_reg    <= ST_OK;
                        if (op_reg == OP_ADD || op_reg == OP_ADDU)
                        begin
                            if (hit_reg)
                                o_st_reg <= ST_DUP;
                            else if (per_in_reg == '0)
                                o_st_reg <= ST_ZERO;
                            else if (n_reg >= NW'(TABLE_DEPTH))
                                o_st_reg <= ST_FULL;
                            else
                                n_reg <= n_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end
endmodule

// ----- rtl/ptt_checker.sv -----
// ----------------------------------------------------------------------------
// ptt_checker: port-level checks of the timer table
// Watches the channels of the top level; bound to it below.
// ----------------------------------------------------------------------------
module ptt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_kind,
    input logic [1:0]  out_status,
    input logic [32:0] out_fire_count,
    input logic        out_found
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken before first finished");
    a_fire: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind |-> out_fire_count != 33'd0 && out_status == 2'd0
        && !out_found)
        else $error("bad fire report");
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_kind |-> out_fire_count == 33'd0)
        else $error("status reply carries fire count");
endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_kind(out_ch.kind), .out_status(out_ch.status),
    .out_fire_count(out_ch.fire_count), .out_found(out_ch.found)
);

// ----- bench/ptt_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// ptt_tb_pkg: bench-side types of the timer table test
// Input item and result item records shared by stimulus and checking.
// ----------------------------------------------------------------------------
package ptt_tb_pkg;
    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  task_id;
        logic [31:0] time_delta;
        logic [31:0] interval;
        logic [15:0] count;
    } cmd_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [7:0]  fired_id;
        logic [32:0] fire_count;
        logic        found;
        logic [31:0] remaining_time;
        logic        last;
    } reply_t;
endpackage

// ----- bench/periodic_timer_table_test.sv -----
// ----------------------------------------------------------------------------
// periodic_timer_table_test: self-checking bench of the periodic timer table
// Directed and random operations are driven in bursts; a behavioral copy of
// the table predicts every reply and fire report, checked in order.
// ----------------------------------------------------------------------------
module periodic_timer_table_test;
    import ptt_pkg::*;
    import ptt_tb_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    ptt_in_if  in_ch ();
    ptt_out_if out_ch ();

    periodic_timer_table u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // table copy
    int          tbl_n;
    logic [7:0]  tbl_id     [DEPTH];
    logic [31:0] tbl_period [DEPTH];
    logic [31:0] tbl_left   [DEPTH];
    logic [15:0] tbl_reps   [DEPTH];
    logic        tbl_inf    [DEPTH];

    cmd_t   pending_cmds [$];
    reply_t expected_replies [$];
    int     errors;
    int     cycles;
    bit     hold_sender;
    int     burst_left;
    int     gap_left;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic reply_t status_reply(logic [1:0] st);
        reply_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void drop_slot(int i);
        for (int j = i; j + 1 < tbl_n; j++)
        begin
            tbl_id[j] = tbl_id[j + 1];
            tbl_period[j] = tbl_period[j + 1];
            tbl_left[j] = tbl_left[j + 1];
            tbl_reps[j] = tbl_reps[j + 1];
            tbl_inf[j] = tbl_inf[j + 1];
        end
        tbl_n--;
    endfunction

    function automatic bit id_in_table(logic [7:0] id);
        for (int i = 0; i < tbl_n; i++)
            if (tbl_id[i] == id)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [1:0] insert_timer(cmd_t c);
        if (c.interval == 0)
            return ST_ZERO;
        if (tbl_n >= DEPTH)
            return ST_FULL;
        tbl_id[tbl_n] = c.task_id;
        tbl_period[tbl_n] = c.interval;
        tbl_left[tbl_n] = c.interval;
        tbl_inf[tbl_n] = (c.count == 0);
        tbl_reps[tbl_n] = (c.count == 0) ? 16'd1 : c.count;
        tbl_n++;
        return ST_OK;
    endfunction

    // predicts the replies of one item and updates the table copy
    function automatic void predict_timers(cmd_t c);
        int i;
        int nfired;
        logic [15:0] amt;
        logic [32:0] over;
        logic [32:0] fires;
        reply_t r;
        nfired = 0;
        i = 0;
        case (c.operation)
            OP_TICK:
            begin
                while (i < tbl_n)
                begin
                    if (tbl_left[i] <= c.time_delta)
                    begin
                        over = {1'b0, c.time_delta - tbl_left[i]};
                        fires = 33'd1;
                        if (over >= {1'b0, tbl_period[i]})
                        begin
                            fires += over / tbl_period[i];
                            tbl_left[i] = 32'(over % tbl_period[i]);
                        end
                        else
                            tbl_left[i] = tbl_period[i] - over[31:0];
                        if (!tbl_inf[i])
                        begin
                            if (fires >= {17'd0, tbl_reps[i]})
                            begin
                                fires = {17'd0, tbl_reps[i]};
                                tbl_reps[i] = '0;
                            end
                            else
                                tbl_reps[i] -= fires[15:0];
                        end
                        r = '0;
                        r.kind = 1'b1;
                        r.fired_id = tbl_id[i];
                        r.fire_count = fires;
                        expected_replies.push_back(r);
                        nfired++;
                    end
                    else
                        tbl_left[i] = tbl_left[i] - c.time_delta;
                    if (!tbl_inf[i] && tbl_reps[i] == 0)
                        drop_slot(i);
                    else
                        i++;
                end
                if (nfired == 0)
                    expected_replies.push_back(status_reply(ST_OK));
                else
                    expected_replies[$].last = 1'b1;
            end
            OP_ADD:
                expected_replies.push_back(status_reply(insert_timer(c)));
            OP_ADDU:
                expected_replies.push_back(status_reply(
                    id_in_table(c.task_id) ? ST_DUP : insert_timer(c)));
            OP_REM:
            begin
                while (i < tbl_n)
                    if (tbl_id[i] == c.task_id)
                        drop_slot(i);
                    else
                        i++;
                expected_replies.push_back(status_reply(ST_OK));
            end
            OP_DEC:
            begin
                amt = c.count;
                while (i < tbl_n)
                begin
                    if (tbl_id[i] != c.task_id)
                        i++;
                    else if (tbl_reps[i] > amt)
                    begin
                        tbl_reps[i] -= amt;
                        tbl_left[i] = tbl_period[i];
                        break;
                    end
                    else if (tbl_reps[i] == amt)
                    begin
                        drop_slot(i);
                        break;
                    end
                    else
                    begin
                        amt -= tbl_reps[i];
                        drop_slot(i);
                    end
                end
                expected_replies.push_back(status_reply(ST_OK));
            end
            OP_QRY:
            begin
                r = status_reply(ST_OK);
                for (i = 0; i < tbl_n; i++)
                    if (tbl_id[i] == c.task_id)
                    begin
                        r.found = 1'b1;
                        r.remaining_time = tbl_left[i];
                        break;
                    end
                expected_replies.push_back(r);
            end
            default:
                expected_replies.push_back(status_reply(ST_OK));
        endcase
    endfunction

    function automatic cmd_t make_cmd(logic [2:0] op, logic [7:0] id, logic [31:0] dt,
                                      logic [31:0] per, logic [15:0] cnt);
        cmd_t c;
        c.operation = op;
        c.task_id = id;
        c.time_delta = dt;
        c.interval = per;
        c.count = cnt;
        return c;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 40);
            1: return $urandom_range(0, 1000);
            2: return $urandom;
            default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.operation <= '0;
            in_ch.task_id <= '0;
            in_ch.time_delta <= '0;
            in_ch.interval <= '0;
            in_ch.count <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid)
                predict_timers(make_cmd(in_ch.operation, in_ch.task_id, in_ch.time_delta,
                                        in_ch.interval, in_ch.count));
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0 && !hold_sender)
            begin
                cmd_t c;
                c = pending_cmds.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.operation <= c.operation;
                in_ch.task_id <= c.task_id;
                in_ch.time_delta <= c.time_delta;
                in_ch.interval <= c.interval;
                in_ch.count <= c.count;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 8);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            cycles <= 0;
        end
        else
        begin
            reply_t got;
            reply_t want;
            cycles <= cycles + 1;
            out_ch.ready <= (cycles % 256 < 64) ? 1'b1 : ($urandom_range(0, 3) != 0);
            if (out_ch.valid && out_ch.ready)
            begin
                got.kind = out_ch.kind;
                got.status = out_ch.status;
                got.fired_id = out_ch.fired_id;
                got.fire_count = out_ch.fire_count;
                got.found = out_ch.found;
                got.remaining_time = out_ch.remaining_time;
                got.last = out_ch.last;
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        errors++;
                    end
                end
            end
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        cmd_t c;
        logic [7:0] id;
        errors = 0;
        tbl_n = 0;
        hold_sender = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every operation, extremes and corner cases
        pending_cmds.push_back(make_cmd(OP_TICK, 8'd0, 32'd0, 32'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_QRY, 8'd7, 32'd0, 32'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_ADD, 8'd1, 32'd0, 32'd0, 16'd3));
        pending_cmds.push_back(make_cmd(OP_ADD, 8'd1, 32'd0, 32'd10, 16'd3));
        pending_cmds.push_back(make_cmd(OP_ADD, 8'd255, 32'd0, 32'hFFFF_FFFF, 16'd0));
        pending_cmds.push_back(make_cmd(OP_ADDU, 8'd1, 32'd0, 32'd5, 16'd1));
        pending_cmds.push_back(make_cmd(OP_ADDU, 8'd2, 32'd0, 32'd4, 16'hFFFF));
        pending_cmds.push_back(make_cmd(OP_ADD, 8'd3, 32'd0, 32'd1, 16'd0));
        pending_cmds.push_back(make_cmd(OP_TICK, 8'd0, 32'd10, 32'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_TICK, 8'd0, 32'd0, 32'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_QRY, 8'd2, 32'd0, 32'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_TICK, 8'd0, 32'hFFFF_FFFF, 32'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_ADD, 8'd4, 32'd0, 32'd7, 16'd5));
        pending_cmds.push_back(make_cmd(OP_ADD, 8'd4, 32'd0, 32'd9, 16'd2));
        pending_cmds.push_back(make_cmd(OP_DEC, 8'd4, 32'd0, 32'd0, 16'd6));
        pending_cmds.push_back(make_cmd(OP_DEC, 8'd255, 32'd0, 32'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_DEC, 8'd255, 32'd0, 32'd0, 16'hFFFF));
        pending_cmds.push_back(make_cmd(OP_REM, 8'd3, 32'd0, 32'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_REM, 8'd9, 32'd0, 32'd0, 16'd0));
        pending_cmds.push_back(make_cmd(3'd6, 8'd0, 32'd0, 32'd0, 16'd0));
        pending_cmds.push_back(make_cmd(3'd7, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        for (int k = 0; k < 17; k++)
            pending_cmds.push_back(make_cmd(OP_ADD, 8'(k % 5), 32'd0, 32'(k + 3), 16'(k % 4)));
        pending_cmds.push_back(make_cmd(OP_TICK, 8'd0, 32'd100, 32'd0, 16'd0));

        // pause until the table has answered everything
        wait (pending_cmds.size() == 0 && !in_ch.valid && expected_replies.size() == 0);
        hold_sender = 1'b1;
        repeat (20) @(posedge clk);
        hold_sender = 1'b0;

        // random: mostly adds and ticks over a small id set, plus the rest
        for (int k = 0; k < 70; k++)
        begin
            id = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
            c = make_cmd(3'($urandom_range(0, 7)), id, rand_word(), rand_word(),
                         16'($urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom));
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    c.operation = OP_ADD;
                    c.interval = $urandom_range(0, 19) == 0 ? 32'd0
                                 : 32'($urandom_range(1, 60));
                end
                3, 4, 5:
                begin
                    c.operation = OP_TICK;
                    if ($urandom_range(0, 5) != 0)
                        c.time_delta = $urandom_range(0, 150);
                end
                default: ;
            endcase
            pending_cmds.push_back(c);
        end
        wait (pending_cmds.size() == 0 && !in_ch.valid && expected_replies.size() == 0);
        repeat (700) @(posedge clk);
        if (errors == 0 && expected_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
